/* rtl/core/kde_pkg.sv */
// Package for the keypad digit entry core: key decode types, decode and segment functions.
package kde_pkg;

	typedef enum logic [1:0] {
		KEY_NONE,
		KEY_DIGIT,
		KEY_DELETE
	} key_kind_t;

	typedef struct packed {
		key_kind_t   kind;
		logic [3:0]  digit;
	} key_t;

	localparam int unsigned NIB_W = 4;
	localparam int unsigned SEL_W = 3;
	localparam int unsigned SEG_W = 8;

	// Line position of the single low line in an active-low nibble.
	typedef struct packed {
		logic        hit;
		logic [1:0]  pos;
	} line_t;

	function automatic line_t one_low(input logic [NIB_W-1:0] nib);
		line_t r;
		r = '{hit: 1'b1, pos: 2'd0};
		case (nib)
			4'h7: r.pos = 2'd0;
			4'hb: r.pos = 2'd1;
			4'hd: r.pos = 2'd2;
			4'he: r.pos = 2'd3;
			default: r.hit = 1'b0;
		endcase
		return r;
	endfunction

	// Code row*4+col: rows 0-2, columns 0-2 give digits 1-9, code 13 gives 0,
	// code 3 deletes.
	function automatic key_t decode_key(input logic [NIB_W-1:0] col_n,
			input logic [NIB_W-1:0] row_n);
		line_t c;
		line_t r;
		key_t  k;
		c = one_low(col_n);
		r = one_low(row_n);
		k = '{kind: KEY_NONE, digit: 4'd0};
		if (c.hit && r.hit) begin
			if (r.pos != 2'd3 && c.pos != 2'd3) begin
				k.kind  = KEY_DIGIT;
				k.digit = 4'({2'b00, r.pos} * 4'd3 + {2'b00, c.pos} + 4'd1);
			end else if (r.pos == 2'd0 && c.pos == 2'd3) begin
				k.kind = KEY_DELETE;
			end else if (r.pos == 2'd3 && c.pos == 2'd1) begin
				k.kind  = KEY_DIGIT;
				k.digit = 4'd0;
			end
		end
		return k;
	endfunction

	function automatic logic [SEG_W-1:0] seg_of(input logic [3:0] d);
		logic [SEG_W-1:0] s;
		case (d)
			4'd0: s = 8'h3f;
			4'd1: s = 8'h06;
			4'd2: s = 8'h5b;
			4'd3: s = 8'h4f;
			4'd4: s = 8'h66;
			4'd5: s = 8'h6d;
			4'd6: s = 8'h7d;
			4'd7: s = 8'h07;
			4'd8: s = 8'h7f;
			4'd9: s = 8'h6f;
			default: s = 8'h00;
		endcase
		return s;
	endfunction

endpackage

/* rtl/core/keypad_digit_entry_display_core.sv */
// A refresh beat is registered in the input stage, then its result is loaded into the
// result register. Throughput: one beat per cycle unless the input stage stalls; a key
// sample held in the input stage never waits on the output side.
// The input stage stalls only while it holds a refresh tick and the result register is held.
// Reset (arst_n low, asynchronous) empties the digit count and scan position; stored digits
// are not cleared and are read only after being written.
module keypad_digit_entry_display_core
	import kde_pkg::*;
#(
	parameter int unsigned MAX_DIGITS = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [3:0] column_lines, [7:4] row_lines
	input  logic        s_tuser,   // command: 0 key sample, 1 refresh tick
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // [2:0] digit_select, [10:3] segments
	output logic        m_tuser    // blank
);

	localparam int unsigned IDX_W = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
	localparam int unsigned CNT_W = $clog2(MAX_DIGITS + 1);

	logic             valid_s1;
	logic             cmd_s1;
	logic [NIB_W-1:0] col_s1;
	logic [NIB_W-1:0] row_s1;

	logic [3:0]       store_q [MAX_DIGITS];
	logic [CNT_W-1:0] count_q;
	logic [IDX_W-1:0] scan_q;

	logic             out_valid_q;
	logic [SEL_W-1:0] sel_q;
	logic [SEG_W-1:0] seg_q;
	logic             blank_q;

	logic             out_free;
	logic             advance;
	key_t             key;

	logic             wr_en;
	logic [IDX_W-1:0] wr_idx;
	logic [3:0]       wr_data;
	logic [CNT_W-1:0] count_d;
	logic [IDX_W-1:0] scan_d;
	logic [IDX_W-1:0] pos;
	logic [CNT_W-1:0] pos_next;
	logic [CNT_W-1:0] rd_off;
	logic [3:0]       rd_digit;

	assign out_free = !out_valid_q || m_tready;
	assign advance  = valid_s1 && (!cmd_s1 || out_free);
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			cmd_s1 <= s_tuser;
			col_s1 <= s_tdata[3:0];
			row_s1 <= s_tdata[7:4];
		end
	end

	assign key = decode_key(col_s1, row_s1);

	always_comb begin
		pos      = (CNT_W'(scan_q) >= count_q) ? '0 : scan_q;
		rd_off   = count_q - CNT_W'(1) - CNT_W'(pos);
		rd_digit = store_q[rd_off[IDX_W-1:0]];
		pos_next = CNT_W'(pos) + CNT_W'(1);
	end

	// Next state for the digit store, count and scan position.
	always_comb begin
		wr_en   = 1'b0;
		wr_idx  = count_q[IDX_W-1:0];
		wr_data = key.digit;
		count_d = count_q;
		scan_d  = scan_q;
		if (advance) begin
			if (!cmd_s1) begin
				case (key.kind)
					KEY_DIGIT: begin
						if (count_q < CNT_W'(MAX_DIGITS)) begin
							wr_en = 1'b1;
							// overwrite a lone leading zero
							if (count_q == CNT_W'(1) && store_q[0] == 4'd0) begin
								wr_idx = '0;
							end else begin
								count_d = count_q + CNT_W'(1);
							end
						end
					end
					KEY_DELETE: begin
						if (count_q != '0) count_d = count_q - CNT_W'(1);
					end
					default: ;
				endcase
			end else if (count_q == '0) begin
				scan_d = '0;
			end else begin
				scan_d = (pos_next >= count_q) ? '0 : pos_next[IDX_W-1:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) store_q[wr_idx] <= wr_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			scan_q  <= '0;
		end else begin
			count_q <= count_d;
			scan_q  <= scan_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= advance && cmd_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && advance && cmd_s1) begin
			if (count_q == '0) begin
				sel_q   <= '0;
				seg_q   <= '0;
				blank_q <= 1'b1;
			end else begin
				sel_q   <= SEL_W'(pos);
				seg_q   <= seg_of(rd_digit);
				blank_q <= 1'b0;
			end
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {5'b00000, seg_q, sel_q};
	assign m_tuser  = blank_q;

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(MAX_DIGITS))
		else $error("digit count above maximum");

	a_scan_bound: assert property (@(posedge clk) disable iff (!arst_n)
		advance && cmd_s1 |=> (scan_q == '0) || (CNT_W'(scan_q) < count_q))
		else $error("scan position left beyond stored digits");

	a_blank_clean: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && blank_q |-> (sel_q == '0) && (seg_q == '0))
		else $error("blank result carries digit data");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> valid_s1 && cmd_s1 && out_valid_q && !m_tready)
		else $error("input stalled without a held refresh result");
`endif

endmodule

/* tb/testbench.sv */
// Testbench for the keypad digit entry core: directed and random beats against a built-in model.
module testbench
	import kde_pkg::*;
();

	localparam int unsigned MAX_DIGITS = 8;
	localparam int RANDOM_BEATS = 1600;
	localparam int STALL_LIMIT = 2000;
	localparam int MAX_REPORTS = 10;
	localparam logic CMD_KEY = 1'b0;
	localparam logic CMD_REFRESH = 1'b1;
	localparam int KEY_CODE_DELETE = 3;
	localparam int KEY_CODE_ZERO = 13;
	// Segment patterns gfedcba, digit 0 in the lowest byte.
	localparam logic [79:0] SEG_ROM = {8'h6f, 8'h7f, 8'h07, 8'h7d, 8'h6d,
			8'h66, 8'h4f, 8'h5b, 8'h06, 8'h3f};

	typedef struct packed {
		logic [SEL_W-1:0] position;
		logic [SEG_W-1:0] pattern;
		logic             blank;
	} frame_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata = 8'h00;   // [3:0] column_lines, [7:4] row_lines
	logic        s_tuser = 1'b0;    // command
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [15:0] m_tdata;           // [2:0] digit_select, [10:3] segments
	logic        m_tuser;           // blank

	// Display model state
	logic [3:0] digits_held [MAX_DIGITS];
	int         held_count = 0;
	int         scan_pos = 0;
	frame_t     pending_frames [$];

	bit quiet_mode = 1'b0;
	int fault_count = 0;
	int stall_cycles = 0;
	int beats_sent = 0;
	int frames_checked = 0;
	int digits_entered = 0;
	int deletes_done = 0;
	int overflow_drops = 0;
	int lone_zero_swaps = 0;
	int blank_frames = 0;
	int stale_positions = 0;
	frame_t seen_frame;
	frame_t want_frame;

	keypad_digit_entry_display_core #(
		.MAX_DIGITS(MAX_DIGITS)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic int draw_gap();
		draw_gap = quiet_mode ? 0 : int'($urandom_range(0, 11));
	endfunction

	// Index of the single low line, or -1 for no key or several keys.
	function automatic int line_index(input logic [3:0] nib);
		case (nib)
			4'h7: line_index = 0;
			4'hb: line_index = 1;
			4'hd: line_index = 2;
			4'he: line_index = 3;
			default: line_index = -1;
		endcase
	endfunction

	function automatic logic [3:0] line_nibble(input int pos);
		line_nibble = 4'hf & ~(4'h8 >> pos);
	endfunction

	function automatic int digit_key_code(input int d);
		digit_key_code = (d == 0) ? KEY_CODE_ZERO : ((d - 1) / 3) * 4 + (d - 1) % 3;
	endfunction

	// Codes outside the digit and delete keys.
	function automatic int ignored_key_code(input int i);
		case (i)
			0: ignored_key_code = 7;
			1: ignored_key_code = 11;
			2: ignored_key_code = 12;
			3: ignored_key_code = 14;
			default: ignored_key_code = 15;
		endcase
	endfunction

	function automatic void store_digit(input int d);
		if (held_count >= MAX_DIGITS) begin
			overflow_drops++;
		end else begin
			// a lone leading zero gives way to the next digit
			if (held_count == 1 && digits_held[0] == 4'd0) begin
				held_count = 0;
				lone_zero_swaps++;
			end
			digits_held[held_count] = 4'(d);
			held_count++;
			digits_entered++;
		end
	endfunction

	function automatic void apply_keypad_beat(input logic cmd, input logic [3:0] col_n,
			input logic [3:0] row_n);
		int col;
		int row;
		int code;
		int p;
		logic [3:0] d;
		frame_t f;
		if (cmd == CMD_KEY) begin
			col = line_index(col_n);
			row = line_index(row_n);
			if (col >= 0 && row >= 0) begin
				code = row * 4 + col;
				if (code == KEY_CODE_DELETE) begin
					if (held_count != 0) begin
						held_count--;
						deletes_done++;
					end
				end else if (code == KEY_CODE_ZERO) begin
					store_digit(0);
				end else if (row != 3 && col != 3) begin
					store_digit(row * 3 + col + 1);
				end
			end
		end else if (held_count == 0) begin
			scan_pos = 0;
			f = '{position: '0, pattern: '0, blank: 1'b1};
			pending_frames.push_back(f);
			blank_frames++;
		end else begin
			p = scan_pos;
			if (p >= held_count) begin
				p = 0;
				stale_positions++;
			end
			d = digits_held[held_count - 1 - p];
			f = '{position: SEL_W'(p), pattern: SEG_ROM[d * 8 +: 8], blank: 1'b0};
			pending_frames.push_back(f);
			p++;
			scan_pos = (p >= held_count) ? 0 : p;
		end
	endfunction

	task automatic log_fault(input string msg);
		fault_count++;
		if (fault_count <= MAX_REPORTS)
			$display("mismatch at %0t: %s", $realtime, msg);
	endtask

	// Called at a falling edge; leaves at a falling edge with tvalid still high.
	task automatic send_beat(input logic cmd, input logic [3:0] col_n, input logic [3:0] row_n);
		int gap;
		gap = draw_gap();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= cmd;
		s_tdata <= {row_n, col_n};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		apply_keypad_beat(cmd, col_n, row_n);
		beats_sent++;
		@(negedge clk);
	endtask

	task automatic send_key(input int code);
		send_beat(CMD_KEY, line_nibble(code % 4), line_nibble(code / 4));
	endtask

	task automatic send_refresh();
		send_beat(CMD_REFRESH, 4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)));
	endtask

	// Hold the sender until every expected frame has come back.
	task automatic wait_for_frames();
		s_tvalid <= 1'b0;
		while (pending_frames.size() != 0)
			@(posedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic test_empty_display();
		send_refresh();
		send_key(KEY_CODE_DELETE);
	endtask

	task automatic test_lone_zero();
		send_key(KEY_CODE_ZERO);
		send_refresh();
		send_key(KEY_CODE_ZERO);
		send_key(digit_key_code(6));
	endtask

	task automatic test_stale_scan();
		send_key(digit_key_code(1));
		send_refresh();
		wait_for_frames();
		send_key(KEY_CODE_DELETE);
		send_refresh();
	endtask

	task automatic test_fill_and_overflow();
		for (int d = 0; d <= 9; d++)
			if (d != 1 && d != 6 && d != 9)
				send_key(digit_key_code(d));
		send_key(digit_key_code(9));
		send_refresh();
		send_refresh();
	endtask

	task automatic test_ignored_patterns();
		send_key(ignored_key_code(0));
		send_key(ignored_key_code(2));
		send_key(ignored_key_code(4));
		send_beat(CMD_KEY, 4'hf, 4'h7);
		send_beat(CMD_KEY, 4'h3, 4'hb);
		send_beat(CMD_KEY, 4'h7, 4'h0);
	endtask

	task automatic test_random_entry();
		int counted;
		int iter;
		int pick;
		int del_pct;
		counted = 0;
		iter = 0;
		while (counted < RANDOM_BEATS) begin
			if (iter % 150 == 0)
				quiet_mode = ($urandom_range(0, 3) == 0);
			if (iter % 400 == 399)
				wait_for_frames();
			pick = $urandom_range(0, 99);
			// lean towards deletes when nearly full so the count keeps moving
			del_pct = (held_count >= 6) ? 45 : 20;
			if (pick < 45) begin
				send_refresh();
			end else if (pick < 85) begin
				if ($urandom_range(0, 99) < del_pct)
					send_key(KEY_CODE_DELETE);
				else
					send_key(digit_key_code($urandom_range(0, 9)));
			end else if (pick < 92) begin
				send_key(ignored_key_code($urandom_range(0, 4)));
			end else begin
				send_beat(CMD_KEY, 4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)));
			end
			counted++;
			iter++;
		end
		quiet_mode = 1'b0;
	endtask

	// Result side: random back-pressure per frame.
	initial begin
		int gap;
		wait (arst_n);
		@(negedge clk);
		forever begin
			gap = draw_gap();
			if (gap > 0) begin
				m_tready <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			m_tready <= 1'b1;
			@(posedge clk);
			while (!m_tvalid)
				@(posedge clk);
			@(negedge clk);
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			seen_frame = '{position: m_tdata[2:0], pattern: m_tdata[10:3], blank: m_tuser};
			frames_checked++;
			if (pending_frames.size() == 0) begin
				log_fault($sformatf("frame with none expected: sel %0d seg %02h blank %0b",
						seen_frame.position, seen_frame.pattern, seen_frame.blank));
			end else begin
				want_frame = pending_frames.pop_front();
				if (seen_frame !== want_frame)
					log_fault($sformatf("expected sel %0d seg %02h blank %0b, got sel %0d seg %02h blank %0b",
							want_frame.position, want_frame.pattern, want_frame.blank,
							seen_frame.position, seen_frame.pattern, seen_frame.blank));
			end
		end
	end

	// Drop the run if nothing moves on either side for too long.
	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			stall_cycles <= 0;
		end else begin
			stall_cycles <= stall_cycles + 1;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("stalled with %0d frames outstanding", pending_frames.size());
				$display("FAILURE");
				$finish;
			end
		end
	end

	initial begin
		repeat (11) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		test_empty_display();
		test_lone_zero();
		test_stale_scan();
		test_fill_and_overflow();
		test_ignored_patterns();
		test_random_entry();
		wait_for_frames();
		repeat (8) @(posedge clk);
		$display("%0d beats: %0d digits entered, %0d deletes, %0d dropped on a full store",
				beats_sent, digits_entered, deletes_done, overflow_drops);
		$display("%0d frames checked: %0d blank, %0d stale positions, %0d lone-zero swaps",
				frames_checked, blank_frames, stale_positions, lone_zero_swaps);
		if (fault_count == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

/* sim.f */
rtl/core/kde_pkg.sv
rtl/core/keypad_digit_entry_display_core.sv
tb/testbench.sv
